### hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check on every edge
`define SLIN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies consequence in the same cycle
`define SLIN_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

`endif

### hw/rtl/slin_pkg.sv
package slin_pkg;

  // width of the sequence length that counts
  localparam int SIZE_BITS = 32;

  // port widths
  localparam int SEQ_W    = 32;
  localparam int VAL_W    = 64;
  localparam int FIRST_W  = 33;
  localparam int COUNT_W  = 32;
  localparam int STRIDE_W = 64;

  // effective size width, bounded by the port
  localparam int SZ_W  = (SIZE_BITS < SEQ_W) ? SIZE_BITS : SEQ_W;
  // clamped bounds lie in [-1, size]
  localparam int IDX_W = SZ_W + 2;

  localparam logic signed [VAL_W-1:0] STEP_ONE     = VAL_W'(1);
  localparam logic signed [VAL_W-1:0] STEP_MIN     = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] STEP_MIN_FIX = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_ZERO_STEP = 1'b1;

  typedef struct packed {
    logic                       status;
    logic signed [FIRST_W-1:0]  first_index;
    logic signed [STRIDE_W-1:0] stride;
  } side_t;

endpackage

### hw/rtl/slice_index_normalizer_unit.sv
// accept to out_valid registers: stage 1, stage 2, divider stages, output register
// throughput: one item per cycle with out_stall low; one quotient bit per divider stage
// a stage moves whenever the stage after it is empty or moving, so bubbles close up
// reset: synchronous, active low; clears all valid bits, payload registers are not reset
`include "assert_macros.svh"

module slice_index_normalizer_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [slin_pkg::SEQ_W-1:0]             in_seq_size,
  input  logic                                   in_start_given,
  input  logic signed [slin_pkg::VAL_W-1:0]      in_start_value,
  input  logic                                   in_stop_given,
  input  logic signed [slin_pkg::VAL_W-1:0]      in_stop_value,
  input  logic                                   in_step_given,
  input  logic signed [slin_pkg::VAL_W-1:0]      in_step_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_status,
  output logic signed [slin_pkg::FIRST_W-1:0]    out_first_index,
  output logic [slin_pkg::COUNT_W-1:0]           out_count,
  output logic signed [slin_pkg::STRIDE_W-1:0]   out_stride
);

  localparam int SZ_W  = slin_pkg::SZ_W;
  localparam int IDX_W = slin_pkg::IDX_W;
  localparam int VAL_W = slin_pkg::VAL_W;

  function automatic logic signed [IDX_W-1:0] adj_bound(
    input logic signed [VAL_W-1:0] v,
    input logic signed [VAL_W-1:0] sz,
    input logic                    fwd
  );
    logic signed [VAL_W-1:0] sum;
    logic signed [VAL_W-1:0] r;
    sum = v + sz;
    if (v < 0) begin
      if (sum < 0) r = fwd ? VAL_W'(0) : -VAL_W'(1);
      else         r = sum;
    end else if (v >= sz) begin
      r = fwd ? sz : sz - VAL_W'(1);
    end else begin
      r = v;
    end
    return IDX_W'(r);
  endfunction

  // ---------------- handshake enables
  logic            en_1, en_2, en_out;
  logic [SZ_W-1:0] en_d;
  logic            v1_r, v2_r, out_valid_r;
  logic [SZ_W-1:0] vd_r;

  assign en_out = !out_valid_r || !out_stall;
  always_comb begin
    en_d[SZ_W-1] = !vd_r[SZ_W-1] || en_out;
    for (int j = SZ_W - 2; j >= 0; j--) begin
      en_d[j] = !vd_r[j] || en_d[j+1];
    end
  end
  assign en_2     = !v2_r || en_d[0];
  assign en_1     = !v1_r || en_2;
  assign in_stall = !en_1;

  // ---------------- stage 1: step fixup, bound adjust, divisor magnitude
  logic signed [VAL_W-1:0] step_eff, step_fix, size_ext, mag;
  logic                    fwd;
  logic signed [IDX_W-1:0] start_nxt, stop_nxt;

  logic                    s1_zero_r, s1_fwd_r, s1_big_r;
  logic signed [IDX_W-1:0] s1_start_r, s1_stop_r;
  logic [SZ_W-1:0]         s1_div_r;
  logic signed [VAL_W-1:0] s1_stride_r;

  always_comb begin
    step_eff = in_step_given ? in_step_value : slin_pkg::STEP_ONE;
    step_fix = (step_eff == slin_pkg::STEP_MIN) ? slin_pkg::STEP_MIN_FIX : step_eff;
    fwd      = !step_fix[VAL_W-1];
    size_ext = VAL_W'(in_seq_size[SZ_W-1:0]);
    mag      = fwd ? step_fix : -step_fix;
    if (in_start_given) start_nxt = adj_bound(in_start_value, size_ext, fwd);
    else                start_nxt = fwd ? IDX_W'(0) : IDX_W'(size_ext - VAL_W'(1));
    if (in_stop_given)  stop_nxt = adj_bound(in_stop_value, size_ext, fwd);
    else                stop_nxt = fwd ? IDX_W'(size_ext) : -IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en_1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_1) begin
      s1_zero_r   <= (step_fix == VAL_W'(0));
      s1_fwd_r    <= fwd;
      s1_start_r  <= start_nxt;
      s1_stop_r   <= stop_nxt;
      s1_big_r    <= |mag[VAL_W-2:SZ_W];
      s1_div_r    <= mag[SZ_W-1:0];
      s1_stride_r <= step_fix;
    end
  end

  // ---------------- stage 2: span and dividend
  logic signed [IDX_W:0]   span;
  logic signed [VAL_W-1:0] start_wide;
  slin_pkg::side_t         side_nxt;

  slin_pkg::side_t s2_side_r;
  logic            s2_empty_r, s2_big_r;
  logic [SZ_W-1:0] s2_dvd_r, s2_div_r;

  always_comb begin
    span = s1_fwd_r ? ((IDX_W+1)'(s1_stop_r) - (IDX_W+1)'(s1_start_r))
                    : ((IDX_W+1)'(s1_start_r) - (IDX_W+1)'(s1_stop_r));
    start_wide = VAL_W'(s1_start_r);
    side_nxt.status      = s1_zero_r ? slin_pkg::STATUS_ZERO_STEP : slin_pkg::STATUS_OK;
    side_nxt.first_index = s1_zero_r ? slin_pkg::FIRST_W'(0)
                                     : start_wide[slin_pkg::FIRST_W-1:0];
    side_nxt.stride      = s1_zero_r ? slin_pkg::STRIDE_W'(0) : s1_stride_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en_2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_2) begin
      s2_side_r  <= side_nxt;
      s2_empty_r <= s1_zero_r || (span <= 0);
      s2_dvd_r   <= SZ_W'(span - (IDX_W+1)'(1));
      s2_big_r   <= s1_big_r;
      s2_div_r   <= s1_div_r;
    end
  end

  // ---------------- divider: one restoring step per stage
  // dq holds the remaining dividend bits on top and the quotient bits below
  logic [SZ_W-1:0] dq_r   [SZ_W];
  logic [SZ_W-1:0] drem_r [SZ_W];
  logic [SZ_W-1:0] ddiv_r [SZ_W];
  logic            dbig_r [SZ_W];
  logic            dempty_r [SZ_W];
  slin_pkg::side_t dside_r [SZ_W];

  for (genvar j = 0; j < SZ_W; j++) begin : g_div
    logic [SZ_W-1:0] src_q, src_rem, src_div;
    logic            src_big, src_empty, src_v;
    slin_pkg::side_t src_side;
    logic [SZ_W:0]   rem_sh, trial;
    logic            take;

    if (j == 0) begin : g_head
      assign src_q     = s2_dvd_r;
      assign src_rem   = '0;
      assign src_div   = s2_div_r;
      assign src_big   = s2_big_r;
      assign src_empty = s2_empty_r;
      assign src_side  = s2_side_r;
      assign src_v     = v2_r;
    end else begin : g_body
      assign src_q     = dq_r[j-1];
      assign src_rem   = drem_r[j-1];
      assign src_div   = ddiv_r[j-1];
      assign src_big   = dbig_r[j-1];
      assign src_empty = dempty_r[j-1];
      assign src_side  = dside_r[j-1];
      assign src_v     = vd_r[j-1];
    end

    always_comb begin
      rem_sh = {src_rem, src_q[SZ_W-1]};
      trial  = rem_sh - {1'b0, src_div};
      // a divisor wider than the dividend never fits
      take   = !src_big && !trial[SZ_W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j] <= 1'b0;
      end else if (en_d[j]) begin
        vd_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en_d[j]) begin
        dq_r[j]     <= {src_q[SZ_W-2:0], take};
        drem_r[j]   <= take ? trial[SZ_W-1:0] : rem_sh[SZ_W-1:0];
        ddiv_r[j]   <= src_div;
        dbig_r[j]   <= src_big;
        dempty_r[j] <= src_empty;
        dside_r[j]  <= src_side;
      end
    end
  end

  // ---------------- output register
  logic [SZ_W:0] q_plus;
  logic          out_status_r;
  logic signed [slin_pkg::FIRST_W-1:0]  out_first_r;
  logic [slin_pkg::COUNT_W-1:0]         out_count_r;
  logic signed [slin_pkg::STRIDE_W-1:0] out_stride_r;

  assign q_plus = (SZ_W+1)'(dq_r[SZ_W-1]) + (SZ_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= vd_r[SZ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_status_r <= dside_r[SZ_W-1].status;
      out_first_r  <= dside_r[SZ_W-1].first_index;
      out_stride_r <= dside_r[SZ_W-1].stride;
      out_count_r  <= dempty_r[SZ_W-1] ? slin_pkg::COUNT_W'(0)
                                       : slin_pkg::COUNT_W'(q_plus);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_index = out_first_r;
  assign out_count       = out_count_r;
  assign out_stride      = out_stride_r;

  // ---------------- checks
  `SLIN_ASSERT_IMPL(a_zero_step_clear, out_valid_r && (out_status_r == slin_pkg::STATUS_ZERO_STEP), (out_count_r == 0) && (out_stride_r == 0) && (out_first_r == 0), "zero step result not cleared")
  `SLIN_ASSERT_IMPL(a_ok_stride, out_valid_r && (out_status_r == slin_pkg::STATUS_OK), out_stride_r != 0, "ok result with zero stride")
  `SLIN_ASSERT_IMPL(a_empty_head_accepts, !v1_r, !in_stall, "input stalled with empty first stage")

endmodule
